// ===== rtl/core/rebd_pkg.sv =====
// ============================================================================
// rebd_pkg
// Shared types, codes and decode tables of the rotary encoder / button decoder.
// ============================================================================
package rebd_pkg;

   // Configuration port geometry
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_DECODER_MODE   = 3'd0;
   localparam logic [2:0] REG_STEPS_PER_NOTCH = 3'd1;
   localparam logic [2:0] REG_CHECK_INTERVAL = 3'd2;
   localparam logic [2:0] REG_HOLD_CHECKS    = 3'd3;
   localparam logic [2:0] REG_DOUBLE_CLICK   = 3'd4;
   localparam logic [2:0] REG_ACCEL_UP       = 3'd5;
   localparam logic [2:0] REG_ACCEL_DOWN     = 3'd6;
   localparam logic [2:0] REG_ACCEL_CEILING  = 3'd7;

   // Register reset values
   localparam logic [1:0]  RST_DECODER_MODE    = 2'd0;
   localparam logic [2:0]  RST_STEPS_PER_NOTCH = 3'd4;
   localparam logic [7:0]  RST_CHECK_INTERVAL  = 8'd10;
   localparam logic [9:0]  RST_HOLD_CHECKS     = 10'd120;
   localparam logic [7:0]  RST_DOUBLE_CLICK    = 8'd60;
   localparam logic [9:0]  RST_ACCEL_UP        = 10'd25;
   localparam logic [9:0]  RST_ACCEL_DOWN      = 10'd2;
   localparam logic [14:0] RST_ACCEL_CEILING   = 15'd3072;

   // Transaction operation codes
   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_READ_VALUE  = 2'd1;
   localparam logic [1:0] OP_READ_BUTTON = 2'd2;

   // Decoder modes
   localparam logic [1:0] MODE_GRAY = 2'd0;
   localparam logic [1:0] MODE_FULL = 2'd1;
   localparam logic [1:0] MODE_HALF = 2'd2;

   // Notch scaling choices
   localparam logic [2:0] NOTCH_TWO  = 3'd2;
   localparam logic [2:0] NOTCH_FOUR = 3'd4;

   // Button events
   localparam logic [2:0] EV_OPEN     = 3'd0;
   localparam logic [2:0] EV_CLICKED  = 3'd1;
   localparam logic [2:0] EV_DOUBLE   = 3'd2;
   localparam logic [2:0] EV_HELD     = 3'd3;
   localparam logic [2:0] EV_RELEASED = 3'd4;

   // Decoded quadrature step
   typedef enum logic [1:0] {
      STEP_NONE = 2'b00,
      STEP_UP   = 2'b01,
      STEP_DOWN = 2'b10
   } step_type;

   // Configuration register set
   typedef struct packed {
      logic [1:0]  decoder_mode;
      logic [2:0]  steps_per_notch;
      logic [7:0]  check_interval;
      logic [9:0]  hold_checks;
      logic [7:0]  double_click_checks;
      logic [9:0]  accel_step_up;
      logic [9:0]  accel_step_down;
      logic [14:0] accel_ceiling;
   } cfg_type;

   // Per-item control handed to the decoding units
   typedef struct packed {
      logic tick_en;
      logic read_en;
   } ctrl_type;

   // Full-step transition table, indexed by {previous AB, current AB}
   function automatic step_type full_step(input logic [3:0] idx);
      step_type s;
      unique case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_UP;
         4'd2, 4'd4, 4'd11, 4'd13: s = STEP_DOWN;
         default:                  s = STEP_NONE;
      endcase
      return s;
   endfunction

   // Half-step transition table
   function automatic step_type half_step(input logic [3:0] idx);
      step_type s;
      unique case (idx)
         4'd7, 4'd8:  s = STEP_UP;
         4'd2, 4'd13: s = STEP_DOWN;
         default:     s = STEP_NONE;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/rotary_encoder_button_decoder_top.sv =====
// ============================================================================
// rotary_encoder_button_decoder_top
// Rotary encoder quadrature decoder with acceleration and click button.
//
//   Channel  Direction  Payload                                  Transfer
//   req_*    in         tuser: op; tdata: pin_a, pin_b, button   tvalid & tready
//   rsp_*    out        tdata: value, button_event               tvalid & tready
//   csr_*    in/out     8 registers at byte address 4*i          APB, pready high
//
// One transaction per cycle unless a read waits on the result side: an item is
// registered on acceptance and fully handled by short logic into the state and
// result registers. A read result goes from the input to the result register.
// Ticks never wait on the result side; reads wait while a result is stalled.
// Synchronous active-high reset clears all but payloads, no clearing pass.
// ============================================================================
module rotary_encoder_button_decoder_top (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [0] pin_a, [1] pin_b,
                                                           // [2] button_level, rest 0
   input  logic [1:0]                         req_tuser,   // [1:0] op
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [7:0] value,
                                                           // [10:8] button_event, rest 0
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rebd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rebd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rebd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   rebd_pkg::cfg_type  cfg;
   rebd_pkg::ctrl_type ctrl;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_op_ff;
   logic               in_a_ff;
   logic               in_b_ff;
   logic               in_btn_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]  rsp_value_ff;
   logic [2:0]         rsp_event_ff;

   logic               out_free;
   logic               needs_rsp;
   logic               proc;
   logic               req_fire;
   logic signed [7:0]  quad_value;
   logic [2:0]         btn_event;

   // Handshake and dispatch
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      needs_rsp    = (in_op_ff == rebd_pkg::OP_READ_VALUE) ||
                     (in_op_ff == rebd_pkg::OP_READ_BUTTON);
      proc         = in_valid_ff && (!needs_rsp || out_free);
      req_tready   = !in_valid_ff || proc;
      req_fire     = req_tvalid && req_tready;
      in_valid_in  = req_fire ? 1'b1 : (proc ? 1'b0 : in_valid_ff);
      ctrl.tick_en = proc && (in_op_ff == rebd_pkg::OP_TICK);
      ctrl.read_en = proc && needs_rsp;
      rsp_valid_in = (proc && needs_rsp) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff  <= req_tuser;
         in_a_ff   <= req_tdata[0];
         in_b_ff   <= req_tdata[1];
         in_btn_ff <= req_tdata[2];
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (proc && needs_rsp) begin
         if (in_op_ff == rebd_pkg::OP_READ_VALUE) begin
            rsp_value_ff <= quad_value;
            rsp_event_ff <= rebd_pkg::EV_OPEN;
         end else begin
            rsp_value_ff <= 8'sd0;
            rsp_event_ff <= btn_event;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_event_ff, rsp_value_ff};

   rebd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rebd_quad u_quad (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .ctrl  ('{tick_en: ctrl.tick_en,
                read_en: ctrl.read_en && (in_op_ff == rebd_pkg::OP_READ_VALUE)}),
      .pin_a (in_a_ff),
      .pin_b (in_b_ff),
      .value (quad_value)
   );

   rebd_button u_button (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .ctrl         ('{tick_en: ctrl.tick_en,
                       read_en: ctrl.read_en && (in_op_ff == rebd_pkg::OP_READ_BUTTON)}),
      .button_level (in_btn_ff),
      .button_event (btn_event)
   );

endmodule

// ===== rtl/core/rebd_csr.sv =====
// ============================================================================
// rebd_csr
// APB-style configuration register file.
// ============================================================================
module rebd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rebd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rebd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rebd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output rebd_pkg::cfg_type                  cfg
);

   rebd_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // Register writes, value masked to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decoder_mode        <= rebd_pkg::RST_DECODER_MODE;
         cfg_ff.steps_per_notch     <= rebd_pkg::RST_STEPS_PER_NOTCH;
         cfg_ff.check_interval      <= rebd_pkg::RST_CHECK_INTERVAL;
         cfg_ff.hold_checks         <= rebd_pkg::RST_HOLD_CHECKS;
         cfg_ff.double_click_checks <= rebd_pkg::RST_DOUBLE_CLICK;
         cfg_ff.accel_step_up       <= rebd_pkg::RST_ACCEL_UP;
         cfg_ff.accel_step_down     <= rebd_pkg::RST_ACCEL_DOWN;
         cfg_ff.accel_ceiling       <= rebd_pkg::RST_ACCEL_CEILING;
      end else if (wr_en) begin
         unique case (reg_idx)
            rebd_pkg::REG_DECODER_MODE:    cfg_ff.decoder_mode        <= csr_pwdata[1:0];
            rebd_pkg::REG_STEPS_PER_NOTCH: cfg_ff.steps_per_notch     <= csr_pwdata[2:0];
            rebd_pkg::REG_CHECK_INTERVAL:  cfg_ff.check_interval      <= csr_pwdata[7:0];
            rebd_pkg::REG_HOLD_CHECKS:     cfg_ff.hold_checks         <= csr_pwdata[9:0];
            rebd_pkg::REG_DOUBLE_CLICK:    cfg_ff.double_click_checks <= csr_pwdata[7:0];
            rebd_pkg::REG_ACCEL_UP:        cfg_ff.accel_step_up       <= csr_pwdata[9:0];
            rebd_pkg::REG_ACCEL_DOWN:      cfg_ff.accel_step_down     <= csr_pwdata[9:0];
            rebd_pkg::REG_ACCEL_CEILING:   cfg_ff.accel_ceiling       <= csr_pwdata[14:0];
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         rebd_pkg::REG_DECODER_MODE:    csr_prdata = {30'd0, cfg_ff.decoder_mode};
         rebd_pkg::REG_STEPS_PER_NOTCH: csr_prdata = {29'd0, cfg_ff.steps_per_notch};
         rebd_pkg::REG_CHECK_INTERVAL:  csr_prdata = {24'd0, cfg_ff.check_interval};
         rebd_pkg::REG_HOLD_CHECKS:     csr_prdata = {22'd0, cfg_ff.hold_checks};
         rebd_pkg::REG_DOUBLE_CLICK:    csr_prdata = {24'd0, cfg_ff.double_click_checks};
         rebd_pkg::REG_ACCEL_UP:        csr_prdata = {22'd0, cfg_ff.accel_step_up};
         rebd_pkg::REG_ACCEL_DOWN:      csr_prdata = {22'd0, cfg_ff.accel_step_down};
         rebd_pkg::REG_ACCEL_CEILING:   csr_prdata = {17'd0, cfg_ff.accel_ceiling};
      endcase
   end

endmodule

// ===== rtl/core/rebd_quad.sv =====
// ============================================================================
// rebd_quad
// Quadrature decode, step count, acceleration and notch value conversion.
// ============================================================================
module rebd_quad (
   input  logic                clock,
   input  logic                reset,
   input  rebd_pkg::cfg_type   cfg,
   input  rebd_pkg::ctrl_type  ctrl,
   input  logic                pin_a,
   input  logic                pin_b,
   output logic signed [7:0]   value
);

   logic [3:0]          hist_ff, hist_in;
   logic [15:0]         step_ff, step_in;
   logic [15:0]         accel_ff, accel_in;

   logic [15:0]         down16;
   logic [15:0]         up16;
   logic [15:0]         ceil16;
   logic [15:0]         accel_dec;
   logic [3:0]          hist_tab;
   logic [1:0]          gray_cur;
   logic [1:0]          gray_diff;
   rebd_pkg::step_type  step_dir;
   logic                table_mode;
   logic                grow;

   logic                neg;
   logic                nonzero;
   logic [15:0]         step_rd;
   logic [8:0]          mag;
   logic [8:0]          mag_neg;

   assign down16 = {6'd0, cfg.accel_step_down};
   assign up16   = {6'd0, cfg.accel_step_up};
   assign ceil16 = {1'b0, cfg.accel_ceiling};

   // Tick: decay, decode, count, grow
   always_comb begin
      accel_dec  = (accel_ff > down16) ? (accel_ff - down16) : 16'd0;
      table_mode = (cfg.decoder_mode == rebd_pkg::MODE_FULL) ||
                   (cfg.decoder_mode == rebd_pkg::MODE_HALF);
      hist_tab   = {hist_ff[1:0], pin_a, pin_b};
      gray_cur   = {pin_a, pin_a ^ pin_b};
      gray_diff  = hist_ff[1:0] - gray_cur;
      hist_in    = hist_ff;
      step_dir   = rebd_pkg::STEP_NONE;
      if (table_mode) begin
         hist_in = hist_tab;
         if (cfg.decoder_mode == rebd_pkg::MODE_FULL) begin
            step_dir = rebd_pkg::full_step(hist_tab);
         end else begin
            step_dir = rebd_pkg::half_step(hist_tab);
         end
      end else if (gray_diff[0]) begin
         hist_in  = {2'b00, gray_cur};
         step_dir = gray_diff[1] ? rebd_pkg::STEP_UP : rebd_pkg::STEP_DOWN;
      end

      unique case (step_dir)
         rebd_pkg::STEP_UP:   step_in = step_ff + 16'd1;
         rebd_pkg::STEP_DOWN: step_in = step_ff - 16'd1;
         default:             step_in = step_ff;
      endcase

      grow = (step_dir != rebd_pkg::STEP_NONE) && (up16 <= ceil16) &&
             (accel_dec <= (ceil16 - up16));
      accel_in = grow ? (accel_dec + up16) : accel_dec;
   end

   // Read: whole notches to accelerated signed value, keep remainder at notch size 2 or 4
   always_comb begin
      neg = step_ff[15];
      unique case (cfg.steps_per_notch)
         rebd_pkg::NOTCH_TWO: begin
            nonzero = |step_ff[15:1];
            step_rd = {15'd0, step_ff[0]};
         end
         rebd_pkg::NOTCH_FOUR: begin
            nonzero = |step_ff[15:2];
            step_rd = {14'd0, step_ff[1:0]};
         end
         default: begin
            nonzero = |step_ff;
            step_rd = 16'd0;
         end
      endcase
      mag     = {1'b0, accel_ff[15:8]} + 9'd1;
      mag_neg = 9'd0 - mag;
      if (!nonzero) begin
         value = 8'sd0;
      end else if (neg) begin
         value = (mag > 9'd128) ? 8'sh80 : $signed(mag_neg[7:0]);
      end else begin
         value = (mag > 9'd127) ? 8'sh7F : $signed(mag[7:0]);
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= 4'd0;
         step_ff  <= 16'd0;
         accel_ff <= 16'd0;
      end else if (ctrl.tick_en) begin
         hist_ff  <= hist_in;
         step_ff  <= step_in;
         accel_ff <= accel_in;
      end else if (ctrl.read_en) begin
         step_ff  <= step_rd;
      end
   end

endmodule

// ===== rtl/core/rebd_button.sv =====
// ============================================================================
// rebd_button
// Button check scheduler and click / double click / hold classifier.
// ============================================================================
module rebd_button (
   input  logic                clock,
   input  logic                reset,
   input  rebd_pkg::cfg_type   cfg,
   input  rebd_pkg::ctrl_type  ctrl,
   input  logic                button_level,
   output logic [2:0]          button_event
);

   logic [7:0]  tsc_ff, tsc_in;
   logic [15:0] kdc_ff, kdc_in;
   logic [7:0]  cw_ff, cw_in;
   logic [2:0]  pend_ff, pend_in;

   logic [8:0]  tick_cnt;
   logic        check;
   logic [7:0]  cw_mid;
   logic [2:0]  pend_mid;

   assign button_event = pend_ff;

   // Check interval counter
   always_comb begin
      tick_cnt = {1'b0, tsc_ff} + 9'd1;
      check    = tick_cnt >= {1'b0, cfg.check_interval};
      tsc_in   = check ? 8'd0 : tick_cnt[7:0];
   end

   // Button classification on a check
   always_comb begin
      kdc_in   = kdc_ff;
      cw_mid   = cw_ff;
      pend_mid = pend_ff;
      if (!button_level) begin
         // pressed: count with saturation, flag hold
         if (kdc_ff != 16'hFFFF) begin
            kdc_in = kdc_ff + 16'd1;
         end
         if (kdc_in > {6'd0, cfg.hold_checks}) begin
            pend_mid = rebd_pkg::EV_HELD;
         end
      end else begin
         // released after a press
         if (kdc_ff != 16'd0) begin
            priority if (pend_ff == rebd_pkg::EV_HELD) begin
               pend_mid = rebd_pkg::EV_RELEASED;
               cw_mid   = 8'd0;
            end else if (cw_ff > 8'd1) begin
               if (cw_ff < cfg.double_click_checks) begin
                  pend_mid = rebd_pkg::EV_DOUBLE;
                  cw_mid   = 8'd0;
               end
            end else begin
               cw_mid = cfg.double_click_checks;
            end
         end
         kdc_in = 16'd0;
      end

      // window countdown; expiry means single click
      cw_in   = cw_mid;
      pend_in = pend_mid;
      if (cw_mid != 8'd0) begin
         cw_in = (cw_mid > 8'd2) ? (cw_mid - 8'd2) : 8'd0;
         if (cw_in == 8'd0) begin
            pend_in = rebd_pkg::EV_CLICKED;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tsc_ff  <= 8'd0;
         kdc_ff  <= 16'd0;
         cw_ff   <= 8'd0;
         pend_ff <= rebd_pkg::EV_OPEN;
      end else if (ctrl.tick_en) begin
         tsc_ff <= tsc_in;
         if (check) begin
            kdc_ff  <= kdc_in;
            cw_ff   <= cw_in;
            pend_ff <= pend_in;
         end
      end else if (ctrl.read_en) begin
         if (pend_ff != rebd_pkg::EV_HELD) begin
            pend_ff <= rebd_pkg::EV_OPEN;
         end
      end
   end

endmodule

// ===== test/encoder_result_checker.sv =====
// ----------------------------------------------------------------------------
// encoder_result_checker
// Watches the request, result and register buses of the rotary encoder /
// button decoder. It keeps its own copy of the decoder state and settings,
// works out the result of every accepted read, and compares each accepted
// result field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module encoder_result_checker
   import rebd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] pin_a, [1] pin_b, [2] button_level
   input  logic [1:0]            req_tuser,   // [1:0] op
   // result stream
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,   // [7:0] value, [10:8] button_event
   // register bus
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   // status toward the testbench top
   output int                    error_count,
   output int                    awaited_count,
   output int                    compared_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] value;
      logic [2:0] button_event;
   } encoder_result_type;

   // settings as seen on the register bus
   cfg_type cfg;

   // decoder state copy
   logic [3:0]  pin_hist;
   logic [15:0] step_cnt;
   logic [15:0] accel;
   logic [15:0] key_down;
   logic [7:0]  click_win;
   logic [7:0]  tick_cnt;
   logic [2:0]  pending_ev;

   encoder_result_type awaited_results[$];
   int errors;
   int compared;

   initial begin
      errors = 0;
      compared = 0;
   end

   task automatic report_error(input string what);
      $display("[%0t] checker: %s", $realtime, what);
      errors++;
   endtask

   // Transition table decode: positions run 00, 01, 11, 10 for forward travel.
   // Half-step counts only forward moves onto 00/11 and backward moves onto 01/10.
   function automatic step_type table_step(input logic [1:0] mode, input logic [3:0] hist);
      logic [1:0] from_pos, to_pos, delta;
      from_pos = {hist[3], hist[3] ^ hist[2]};
      to_pos   = {hist[1], hist[1] ^ hist[0]};
      delta    = to_pos - from_pos;
      if (mode == MODE_FULL) begin
         if (delta == 2'd1) return STEP_UP;
         if (delta == 2'd3) return STEP_DOWN;
         return STEP_NONE;
      end
      if (delta == 2'd1 && hist[1] == hist[0]) return STEP_UP;
      if (delta == 2'd3 && hist[1] != hist[0]) return STEP_DOWN;
      return STEP_NONE;
   endfunction

   // Button classification, run once per check interval
   function automatic void check_button(input logic level);
      if (!level) begin
         if (key_down != 16'hFFFF) key_down = key_down + 16'd1;
         if (key_down > cfg.hold_checks) pending_ev = EV_HELD;
      end else begin
         if (key_down != 16'd0) begin
            if (pending_ev == EV_HELD) begin
               pending_ev = EV_RELEASED;
               click_win = 8'd0;
            end else if (click_win > 8'd1) begin
               if (click_win < cfg.double_click_checks) begin
                  pending_ev = EV_DOUBLE;
                  click_win = 8'd0;
               end
            end else begin
               click_win = cfg.double_click_checks;
            end
         end
         key_down = 16'd0;
      end
      // click window runs down two per check; running out means a single click
      if (click_win > 8'd0) begin
         click_win = (click_win > 8'd2) ? click_win - 8'd2 : 8'd0;
         if (click_win == 8'd0) pending_ev = EV_CLICKED;
      end
   endfunction

   // One tick: decay, decode, count, grow, button schedule
   function automatic void predict_tick(input logic a, input logic b, input logic level);
      logic [1:0] gray_now, gray_diff;
      step_type   s;
      int         cnt;
      s = STEP_NONE;
      accel = (accel > cfg.accel_step_down) ? accel - 16'(cfg.accel_step_down) : 16'd0;

      if (cfg.decoder_mode == MODE_FULL || cfg.decoder_mode == MODE_HALF) begin
         pin_hist = {pin_hist[1:0], a, b};
         s = table_step(cfg.decoder_mode, pin_hist);
      end else begin
         // Gray difference; unused mode decodes the same way
         gray_now  = {a, a ^ b};
         gray_diff = pin_hist[1:0] - gray_now;
         if (gray_diff[0]) begin
            pin_hist = {2'b00, gray_now};
            s = gray_diff[1] ? STEP_UP : STEP_DOWN;
         end
      end

      case (s)
         STEP_UP:   step_cnt = step_cnt + 16'd1;
         STEP_DOWN: step_cnt = step_cnt - 16'd1;
         default:   ;
      endcase

      if (s != STEP_NONE && cfg.accel_step_up <= cfg.accel_ceiling &&
          int'(accel) <= int'(cfg.accel_ceiling) - int'(cfg.accel_step_up))
         accel = accel + 16'(cfg.accel_step_up);

      cnt = int'(tick_cnt) + 1;
      if (cnt >= int'(cfg.check_interval)) begin
         tick_cnt = 8'd0;
         check_button(level);
      end else begin
         tick_cnt = 8'(cnt);
      end
   endfunction

   // Whole notches out as one accelerated step, remainder kept at notch size 2 or 4
   function automatic logic [7:0] take_notches();
      logic negative, nonzero;
      int   mag;
      negative = step_cnt[15];
      case (cfg.steps_per_notch)
         NOTCH_TWO: begin
            nonzero  = negative || (step_cnt[15:1] != 15'd0);
            step_cnt = step_cnt & 16'h0001;
         end
         NOTCH_FOUR: begin
            nonzero  = negative || (step_cnt[15:2] != 14'd0);
            step_cnt = step_cnt & 16'h0003;
         end
         default: begin
            nonzero  = (step_cnt != 16'd0);
            step_cnt = 16'd0;
         end
      endcase
      if (!nonzero) return 8'h00;
      mag = 1 + int'(accel[15:8]);
      if (negative) return (mag > 128) ? 8'h80 : 8'(-mag);
      return (mag > 127) ? 8'h7F : 8'(mag);
   endfunction

   // Register bus writes update the settings copy
   function automatic void apply_write(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         REG_DECODER_MODE:    cfg.decoder_mode        = data[1:0];
         REG_STEPS_PER_NOTCH: cfg.steps_per_notch     = data[2:0];
         REG_CHECK_INTERVAL:  cfg.check_interval      = data[7:0];
         REG_HOLD_CHECKS:     cfg.hold_checks         = data[9:0];
         REG_DOUBLE_CLICK:    cfg.double_click_checks = data[7:0];
         REG_ACCEL_UP:        cfg.accel_step_up       = data[9:0];
         REG_ACCEL_DOWN:      cfg.accel_step_down     = data[9:0];
         REG_ACCEL_CEILING:   cfg.accel_ceiling       = data[14:0];
         default:             ;
      endcase
   endfunction

   // Bus monitor: compare results first, then predict the new transaction
   always @(posedge clock) begin
      encoder_result_type got, want;
      if (reset) begin
         cfg.decoder_mode        = RST_DECODER_MODE;
         cfg.steps_per_notch     = RST_STEPS_PER_NOTCH;
         cfg.check_interval      = RST_CHECK_INTERVAL;
         cfg.hold_checks         = RST_HOLD_CHECKS;
         cfg.double_click_checks = RST_DOUBLE_CLICK;
         cfg.accel_step_up       = RST_ACCEL_UP;
         cfg.accel_step_down     = RST_ACCEL_DOWN;
         cfg.accel_ceiling       = RST_ACCEL_CEILING;
         pin_hist   = 4'd0;
         step_cnt   = 16'd0;
         accel      = 16'd0;
         key_down   = 16'd0;
         click_win  = 8'd0;
         tick_cnt   = 8'd0;
         pending_ev = EV_OPEN;
         awaited_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_write(csr_paddr[4:2], csr_pwdata);

         if (rsp_tvalid && rsp_tready) begin
            got.value        = rsp_tdata[7:0];
            got.button_event = rsp_tdata[10:8];
            if (awaited_results.size() == 0) begin
               report_error($sformatf("result %h with nothing expected", rsp_tdata));
            end else begin
               want = awaited_results.pop_front();
               compared++;
               if (got.value !== want.value)
                  report_error($sformatf("value %0d, expected %0d",
                                         $signed(got.value), $signed(want.value)));
               if (got.button_event !== want.button_event)
                  report_error($sformatf("button event %0d, expected %0d",
                                         got.button_event, want.button_event));
            end
         end

         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_TICK: predict_tick(req_tdata[0], req_tdata[1], req_tdata[2]);
               OP_READ_VALUE: begin
                  want.value        = take_notches();
                  want.button_event = EV_OPEN;
                  awaited_results.push_back(want);
               end
               OP_READ_BUTTON: begin
                  want.value        = 8'h00;
                  want.button_event = pending_ev;
                  if (pending_ev != EV_HELD) pending_ev = EV_OPEN;
                  awaited_results.push_back(want);
               end
               default: ;
            endcase
         end
      end
      error_count    <= errors;
      awaited_count  <= awaited_results.size();
      compared_count <= compared;
   end

endmodule

// ===== test/rotary_encoder_button_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder_top_tb
// Drives encoder ticks, value reads and button reads into the decoder under a
// series of register settings, with random gaps on both streams and one long
// result-side hold-off. Checking is done by encoder_result_checker.
// ----------------------------------------------------------------------------
module rotary_encoder_button_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rebd_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 400;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'd0;   // [0] pin_a, [1] pin_b, [2] button_level
   logic [1:0]            req_tuser   = 2'd0;   // [1:0] op
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [15:0]           rsp_tdata;            // [7:0] value, [10:8] button_event
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int error_count, awaited_count, compared_count;

   // stimulus bookkeeping
   logic [1:0] enc_pos   = 2'd0;
   logic       btn_level = 1'b1;
   int items_sent    = 0;
   int settings_used = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 47;
   int stall_asked   = 0;
   int cur_interval  = 10;
   int cur_hold      = 120;
   int cur_dbl       = 60;

   rotary_encoder_button_decoder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   encoder_result_checker result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .error_count    (error_count),
      .awaited_count  (awaited_count),
      .compared_count (compared_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      int hold_left, stalls_done;
      hold_left = 0;
      stalls_done = 0;
      forever begin
         @(posedge clock);
         if (stall_asked > stalls_done) begin
            stalls_done++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("rotary_encoder_button_decoder_top_tb: done, errors");
      $finish;
   end

   // One request transaction; valid stays up until accepted
   task automatic send_item(input logic [1:0] op, input logic a, input logic b,
                            input logic btn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, btn, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic emit_tick();
      send_item(OP_TICK, enc_pos[1], enc_pos[1] ^ enc_pos[0], btn_level);
   endtask

   task automatic read_value();
      send_item(OP_READ_VALUE, 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic read_button();
      send_item(OP_READ_BUTTON, 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Knob turn with occasional dwell and contact bounce
   task automatic turn(input int dir, input int steps);
      repeat (steps) begin
         enc_pos = (dir > 0) ? enc_pos + 2'd1 : enc_pos - 2'd1;
         emit_tick();
         if ($urandom_range(9) == 0) emit_tick();
         if ($urandom_range(9) == 0) begin
            enc_pos = (dir > 0) ? enc_pos - 2'd1 : enc_pos + 2'd1;
            emit_tick();
            enc_pos = (dir > 0) ? enc_pos + 2'd1 : enc_pos - 2'd1;
            emit_tick();
         end
      end
   endtask

   // Ticks for a number of button checks, capped to keep runs short
   function automatic int span(input int checks);
      int t;
      t = cur_interval * checks;
      if (t > 48) t = 48;
      if (t < 1) t = 1;
      return t;
   endfunction

   task automatic keep_button(input logic level, input int ticks);
      btn_level = level;
      repeat (ticks) emit_tick();
   endtask

   // Wait until every read has been answered, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int mode, input int notch, input int interval,
                             input int hold, input int dbl, input int up,
                             input int down, input int ceiling);
      drain();
      csr_write(REG_DECODER_MODE,    32'(mode));
      csr_write(REG_STEPS_PER_NOTCH, 32'(notch));
      csr_write(REG_CHECK_INTERVAL,  32'(interval));
      csr_write(REG_HOLD_CHECKS,     32'(hold));
      csr_write(REG_DOUBLE_CLICK,    32'(dbl));
      csr_write(REG_ACCEL_UP,        32'(up));
      csr_write(REG_ACCEL_DOWN,      32'(down));
      csr_write(REG_ACCEL_CEILING,   32'(ceiling));
      cur_interval = interval;
      cur_hold     = hold;
      cur_dbl      = dbl;
      settings_used++;
   endtask

   // Mostly well-formed gestures with random content, some raw noise
   task automatic run_random(input int count);
      int stop, pick;
      logic [1:0] op;
      logic a, b, btn;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            turn($urandom_range(1) ? 1 : -1, $urandom_range(1, 8));
         end else if (pick < 48) begin
            // single press, possibly long enough to count as held
            keep_button(1'b0, span($urandom_range(1, cur_hold + 2)));
            keep_button(1'b1, span($urandom_range(1, cur_dbl / 2 + 2)));
         end else if (pick < 60) begin
            // two short presses inside the double click window
            keep_button(1'b0, span($urandom_range(1, 2)));
            keep_button(1'b1, span($urandom_range(1, cur_dbl / 4 + 1)));
            keep_button(1'b0, span($urandom_range(1, 2)));
            keep_button(1'b1, span(cur_dbl / 2 + 2));
         end else if (pick < 78) begin
            read_value();
         end else if (pick < 92) begin
            read_button();
         end else begin
            op  = 2'($urandom);
            a   = 1'($urandom);
            b   = 1'($urandom);
            btn = 1'($urandom);
            send_item(op, a, b, btn);
            if (op == OP_TICK) begin
               enc_pos   = {a, a ^ b};
               btn_level = btn;
            end
         end
      end
   endtask

   // main sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings
      read_value();
      read_button();
      repeat (4) begin
         enc_pos = enc_pos + 2'd1;
         emit_tick();
      end
      read_value();
      repeat (6) begin
         enc_pos = enc_pos - 2'd1;
         emit_tick();
      end
      read_value();
      send_item(OP_UNUSED, 1'b1, 1'b1, 1'b0);
      keep_button(1'b0, 1);
      read_button();
      keep_button(1'b1, 1);
      read_value();
      send_item(OP_UNUSED, 1'b0, 1'b0, 1'b1);
      send_item(OP_READ_BUTTON, 1'b1, 1'b1, 1'b0);
      send_item(OP_READ_VALUE, 1'b0, 1'b0, 1'b1);

      // sender idles 26, receiver 47
      set_config(MODE_FULL, NOTCH_TWO, 1, 4, 6, 300, 5, 2000);
      run_random(100);
      // fast acceleration to saturation, odd click window
      set_config(MODE_HALF, NOTCH_FOUR, 2, 1, 3, 1023, 0, 32767);
      run_random(100);

      // sender idles 47, receiver 26; long result hold-off
      send_idle_pct = 47;
      recv_idle_pct = 26;
      set_config(MODE_UNUSED, 1, 3, 1023, 254, 40, 1023, 10);
      stall_asked++;
      run_random(80);
      set_config(MODE_GRAY, 3, 255, 2, 2, 0, 1, 0);
      run_random(60);

      // no idling, random settings
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (3) begin
         set_config($urandom_range(0, 3), $urandom_range(1, 4), $urandom_range(1, 4),
                    $urandom_range(1, 12), $urandom_range(2, 12),
                    $urandom_range(0, 1023), $urandom_range(0, 40),
                    $urandom_range(0, 32767));
         run_random(70);
      end

      drain();
      $display("summary: %0d request transactions, %0d results compared, %0d settings",
               items_sent, compared_count, settings_used);
      $display("summary: all decoder modes, notch sizes, button events and a long stall");
      if (error_count == 0 && awaited_count == 0)
         $display("rotary_encoder_button_decoder_top_tb: done, clean");
      else
         $display("rotary_encoder_button_decoder_top_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rebd_pkg.sv
rtl/core/rebd_csr.sv
rtl/core/rebd_quad.sv
rtl/core/rebd_button.sv
rtl/core/rotary_encoder_button_decoder_top.sv
test/encoder_result_checker.sv
test/rotary_encoder_button_decoder_top_tb.sv
